@@ rtl/core/kpi_pkg.sv @@
package kpi_pkg;

  localparam int NUM_CH = 7;
  localparam int CH_W   = 3;
  localparam int WORD_W = 32;
  localparam int STEP_W = 16;
  localparam int OUT_FC_W = 5;
  localparam logic [STEP_W-1:0] STEPS_RESET = 16'd190;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_SAVE = 2'd1;
  localparam logic [1:0] OP_PLAY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SAVE,
    ST_RD_CUR,
    ST_RD_NXT,
    ST_DIFF,
    ST_DIV
  } kpi_state_t;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [WORD_W-1:0] pos_x_in;
    logic signed [WORD_W-1:0] pos_y_in;
    logic signed [WORD_W-1:0] pos_z_in;
    logic signed [WORD_W-1:0] body_rot_in;
    logic signed [WORD_W-1:0] head_rot_in;
    logic signed [WORD_W-1:0] right_arm_rot_in;
    logic signed [WORD_W-1:0] left_arm_rot_in;
  } kpi_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] pos_z;
    logic signed [WORD_W-1:0] body_rot;
    logic signed [WORD_W-1:0] head_rot;
    logic signed [WORD_W-1:0] right_arm_rot;
    logic signed [WORD_W-1:0] left_arm_rot;
    logic                     playing;
    logic [OUT_FC_W-1:0]      stored_frames;
  } kpi_out_t;

  // Pick one channel of the incoming pose.
  function automatic logic [WORD_W-1:0] kpi_in_word(kpi_in_t d, logic [CH_W-1:0] ch);
    logic [WORD_W-1:0] w;
    case (ch)
      3'd0: w = d.pos_x_in;
      3'd1: w = d.pos_y_in;
      3'd2: w = d.pos_z_in;
      3'd3: w = d.body_rot_in;
      3'd4: w = d.head_rot_in;
      3'd5: w = d.right_arm_rot_in;
      default: w = d.left_arm_rot_in;
    endcase
    return w;
  endfunction

endpackage

@@ rtl/core/keyframe_pose_interpolator.sv @@
// Keyframe pose player for a seven-channel Q16.16 pose. Issue a command with
// start while busy is low; the pose, the playing flag and the frame count
// after that command appear on out_data for exactly one cycle with out_valid,
// and the receiver cannot stall them, so capture them on that cycle. A tick
// that only moves the pose, a tick while stopped, a stop and an ignored save
// give their result on the next cycle. A save writes seven words through the
// single keyframe RAM write port. Starting playback and every segment change
// recompute the seven increments, one channel after another, through one
// shared radix-2 divider (33 quotient bits per channel) fed by the registered
// RAM read port. The keyframe RAM needs no clearing, since only saved slots
// are ever read.
module keyframe_pose_interpolator #(
  parameter int MAX_KEYFRAMES = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  kpi_pkg::kpi_in_t  in_data,
  output logic              out_valid,
  output kpi_pkg::kpi_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  import kpi_pkg::*;

  localparam int DEPTH = MAX_KEYFRAMES * NUM_CH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SEG_W = $clog2(MAX_KEYFRAMES);
  localparam int FC_W  = $clog2(MAX_KEYFRAMES + 1);

  kpi_state_t        state_r, state_nxt;
  logic [CH_W-1:0]   ch_r, ch_nxt;
  logic [SEG_W-1:0]  seg_r, seg_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [FC_W-1:0]   fc_r, fc_nxt;
  logic              play_r, play_nxt;
  logic              load_pose_r, load_pose_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [STEP_W-1:0] sps_r;
  logic [WORD_W-1:0] cur_r, cur_nxt;
  kpi_in_t           hold_r, hold_nxt;
  logic [WORD_W-1:0] pose_r [NUM_CH];
  logic [WORD_W-1:0] pose_nxt [NUM_CH];
  logic [WORD_W-1:0] inc_r [NUM_CH];
  logic [WORD_W-1:0] inc_nxt [NUM_CH];

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  logic              div_start;
  logic signed [32:0] div_dividend;
  logic [STEP_W-1:0] div_den;
  logic              div_done;
  logic [WORD_W-1:0] div_quot;

  logic              accept;
  logic              cfg_wr;
  logic [AW-1:0]     seg_base;
  logic [AW-1:0]     fc_base;
  logic [FC_W:0]     seg_p2;

  assign accept = start && !busy;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // slot base addresses: slot * 7 as shift and subtract
  assign seg_base = (AW'(seg_r) << 3) - AW'(seg_r);
  assign fc_base  = (AW'(fc_r) << 3) - AW'(fc_r);
  // after a segment advance, seg_r + 1 is the new index; the run ends when
  // new index + 2 exceeds the frame count
  assign seg_p2   = (FC_W + 1)'(seg_r) + (FC_W + 1)'(3);

  assign div_den      = (sps_r == '0) ? STEP_W'(1) : sps_r;
  assign div_dividend = {ram_rdata[WORD_W-1], ram_rdata} - {cur_r[WORD_W-1], cur_r};

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    seg_nxt       = seg_r;
    step_nxt      = step_r;
    fc_nxt        = fc_r;
    play_nxt      = play_r;
    load_pose_nxt = load_pose_r;
    out_valid_nxt = 1'b0;
    cur_nxt       = cur_r;
    hold_nxt      = hold_r;
    pose_nxt      = pose_r;
    inc_nxt       = inc_r;
    ram_we        = 1'b0;
    ram_waddr     = fc_base + AW'(ch_r);
    ram_wdata     = kpi_in_word(hold_r, ch_r);
    ram_raddr     = seg_base + AW'(ch_r);
    div_start     = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_data.opcode)
            OP_SAVE: begin
              if (fc_r < FC_W'(MAX_KEYFRAMES)) begin
                hold_nxt  = in_data;
                ch_nxt    = '0;
                state_nxt = ST_SAVE;
              end else begin
                out_valid_nxt = 1'b1;
              end
            end
            OP_PLAY: begin
              if (!play_r && fc_r > FC_W'(1)) begin
                seg_nxt       = '0;
                step_nxt      = '0;
                ch_nxt        = '0;
                load_pose_nxt = 1'b1;
                state_nxt     = ST_RD_CUR;
              end else begin
                play_nxt      = 1'b0;
                out_valid_nxt = 1'b1;
              end
            end
            OP_TICK: begin
              if (play_r && step_r >= sps_r) begin
                // segment end: advance or stop, the pose holds
                if (seg_p2 > (FC_W + 1)'(fc_r)) begin
                  seg_nxt       = '0;
                  play_nxt      = 1'b0;
                  out_valid_nxt = 1'b1;
                end else begin
                  seg_nxt       = seg_r + SEG_W'(1);
                  step_nxt      = '0;
                  ch_nxt        = '0;
                  load_pose_nxt = 1'b0;
                  state_nxt     = ST_RD_CUR;
                end
              end else begin
                if (play_r) begin
                  for (int c = 0; c < NUM_CH; c++) begin
                    pose_nxt[c] = pose_r[c] + inc_r[c];
                  end
                  step_nxt = step_r + STEP_W'(1);
                end
                out_valid_nxt = 1'b1;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      ST_SAVE: begin
        ram_we = 1'b1;
        ch_nxt = ch_r + CH_W'(1);
        if (ch_r == CH_W'(NUM_CH - 1)) begin
          fc_nxt        = fc_r + FC_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      ST_RD_CUR: begin
        ram_raddr = seg_base + AW'(ch_r);
        state_nxt = ST_RD_NXT;
      end

      ST_RD_NXT: begin
        // current-frame word lands now; ask for the next-frame word
        ram_raddr = seg_base + AW'(NUM_CH) + AW'(ch_r);
        cur_nxt   = ram_rdata;
        state_nxt = ST_DIFF;
      end

      ST_DIFF: begin
        if (load_pose_r) begin
          pose_nxt[ch_r] = cur_r;
        end
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          inc_nxt[ch_r] = div_quot;
          ch_nxt        = ch_r + CH_W'(1);
          if (ch_r == CH_W'(NUM_CH - 1)) begin
            play_nxt      = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_RD_CUR;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ch_r        <= '0;
      seg_r       <= '0;
      step_r      <= '0;
      fc_r        <= '0;
      play_r      <= 1'b0;
      load_pose_r <= 1'b0;
      out_valid_r <= 1'b0;
      sps_r       <= STEPS_RESET;
      for (int c = 0; c < NUM_CH; c++) begin
        pose_r[c] <= '0;
        inc_r[c]  <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      seg_r       <= seg_nxt;
      step_r      <= step_nxt;
      fc_r        <= fc_nxt;
      play_r      <= play_nxt;
      load_pose_r <= load_pose_nxt;
      out_valid_r <= out_valid_nxt;
      pose_r      <= pose_nxt;
      inc_r       <= inc_nxt;
      // the only register answers at offsets 0 to 3 (paddr[2] low)
      if (cfg_wr && !cfg_paddr[2]) begin
        sps_r <= cfg_pwdata[STEP_W-1:0];
      end
    end
    cur_r  <= cur_nxt;
    hold_r <= hold_nxt;
  end

  kpi_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  kpi_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_den),
    .done    (div_done),
    .quot    (div_quot)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  // present the live state; it holds while idle, so it is the result of the
  // command that just finished
  assign out_data.pos_x         = pose_r[0];
  assign out_data.pos_y         = pose_r[1];
  assign out_data.pos_z         = pose_r[2];
  assign out_data.body_rot      = pose_r[3];
  assign out_data.head_rot      = pose_r[4];
  assign out_data.right_arm_rot = pose_r[5];
  assign out_data.left_arm_rot  = pose_r[6];
  assign out_data.playing       = play_r;
  assign out_data.stored_frames = OUT_FC_W'(fc_r);

  assign cfg_pready = 1'b1;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, sps_r};

endmodule

@@ rtl/core/kpi_ram.sv @@
module kpi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 112
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/kpi_div.sv @@
module kpi_div (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [32:0]  dividend,
  input  logic [15:0]         divisor,
  output logic                done,
  output logic [31:0]         quot
);

  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] work_r, work_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic [16:0] shifted;
  logic [16:0] trial;
  logic        fits;

  // restoring divide on magnitudes, one quotient bit per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    shifted  = {rem_r, work_r[32]};
    trial    = shifted - {1'b0, den_r};
    fits     = (shifted >= {1'b0, den_r});
    if (start) begin
      busy_nxt = 1'b1;
      neg_nxt  = dividend[32];
      work_nxt = dividend[32] ? 33'(-dividend) : 33'(dividend);
      rem_nxt  = '0;
      den_nxt  = divisor;
      cnt_nxt  = 6'd32;
    end else if (busy_r) begin
      rem_nxt  = fits ? trial[15:0] : shifted[15:0];
      work_nxt = {work_r[31:0], fits};
      cnt_nxt  = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = neg_r ? (32'd0 - work_r[31:0]) : work_r[31:0];

endmodule

@@ dv/kpi_pose_checker.sv @@
`timescale 1ns / 1ps

module kpi_pose_checker #(
  parameter int         MAX_KEYFRAMES = 16,
  parameter logic [2:0] STEPS_ADDR    = 3'd0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              busy,
  input  kpi_pkg::kpi_in_t  in_data,
  input  logic              out_valid,
  input  kpi_pkg::kpi_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [2:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic              cfg_pready,
  output int                pending,
  output int                errors
);

  import kpi_pkg::*;

  logic [WORD_W-1:0] key_words [MAX_KEYFRAMES*NUM_CH];
  logic [WORD_W-1:0] step_delta [NUM_CH];
  logic [WORD_W-1:0] pose_now [NUM_CH];
  int unsigned       frames_held;
  int unsigned       segment;
  int unsigned       ticks_done;
  logic              playing_now;
  logic [STEP_W-1:0] seg_steps;
  kpi_out_t          expected_poses [$];
  kpi_out_t          want;
  int                fail_cnt;

  // Per-channel increment for the current segment, truncated toward zero.
  task automatic load_deltas();
    longint      divisor;
    longint      diff;
    int unsigned base;
    int          c;
    if (segment + 1 >= MAX_KEYFRAMES) return;
    divisor = (seg_steps == '0) ? 64'sd1 : longint'(seg_steps);
    base    = segment * NUM_CH;
    for (c = 0; c < NUM_CH; c++) begin
      diff = longint'($signed(key_words[base + NUM_CH + c]))
           - longint'($signed(key_words[base + c]));
      step_delta[c] = WORD_W'(diff / divisor);
    end
  endtask

  task automatic advance_pose(input kpi_in_t cmd);
    kpi_out_t snap;
    int       c;
    case (cmd.opcode)
      OP_SAVE: begin
        if (frames_held < MAX_KEYFRAMES) begin
          for (c = 0; c < NUM_CH; c++)
            key_words[frames_held*NUM_CH + c] = cmd[WORD_W*(NUM_CH-1-c) +: WORD_W];
          frames_held++;
        end
      end
      OP_PLAY: begin
        if (!playing_now && frames_held > 1) begin
          for (c = 0; c < NUM_CH; c++) pose_now[c] = key_words[c];
          segment    = 0;
          ticks_done = 0;
          load_deltas();
          playing_now = 1'b1;
        end else begin
          playing_now = 1'b0;
        end
      end
      OP_TICK: begin
        if (playing_now) begin
          if (ticks_done >= seg_steps) begin
            segment++;
            if (segment + 2 > frames_held) begin
              segment     = 0;
              playing_now = 1'b0;
            end else begin
              ticks_done = 0;
              load_deltas();
            end
          end else begin
            for (c = 0; c < NUM_CH; c++) pose_now[c] = pose_now[c] + step_delta[c];
            ticks_done = (ticks_done + 1) & 32'h0000_FFFF;
          end
        end
      end
      default: ;
    endcase
    snap.pos_x         = pose_now[0];
    snap.pos_y         = pose_now[1];
    snap.pos_z         = pose_now[2];
    snap.body_rot      = pose_now[3];
    snap.head_rot      = pose_now[4];
    snap.right_arm_rot = pose_now[5];
    snap.left_arm_rot  = pose_now[6];
    snap.playing       = playing_now;
    snap.stored_frames = OUT_FC_W'(frames_held);
    expected_poses = {expected_poses, snap};
  endtask

  task automatic check_field(input string name, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %h, actual %h", name, exp_val, act_val);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        step_delta[c] = '0;
        pose_now[c]   = '0;
      end
      frames_held = 0;
      segment     = 0;
      ticks_done  = 0;
      playing_now = 1'b0;
      seg_steps   = STEPS_RESET;
      expected_poses.delete();
    end else begin
      if (out_valid) begin
        if (expected_poses.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_cnt++;
        end else begin
          want = expected_poses.pop_front();
          check_field("pos_x", want.pos_x, out_data.pos_x);
          check_field("pos_y", want.pos_y, out_data.pos_y);
          check_field("pos_z", want.pos_z, out_data.pos_z);
          check_field("body_rot", want.body_rot, out_data.body_rot);
          check_field("head_rot", want.head_rot, out_data.head_rot);
          check_field("right_arm_rot", want.right_arm_rot, out_data.right_arm_rot);
          check_field("left_arm_rot", want.left_arm_rot, out_data.left_arm_rot);
          check_field("playing", 32'(want.playing), 32'(out_data.playing));
          check_field("stored_frames", 32'(want.stored_frames), 32'(out_data.stored_frames));
        end
      end
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == STEPS_ADDR)
        seg_steps = cfg_pwdata[STEP_W-1:0];
      if (start && !busy) advance_pose(in_data);
    end
    pending <= expected_poses.size();
    errors  <= fail_cnt;
  end

endmodule

@@ dv/tb_keyframe_pose_interpolator.sv @@
`timescale 1ns / 1ps

module tb_keyframe_pose_interpolator;
  import kpi_pkg::*;

  localparam int         KEYFRAMES   = 16;
  localparam logic [2:0] REG_STEPS   = 3'd0;
  // Opcode 3 is unused by the block: it reports state and changes nothing.
  localparam logic [1:0] OP_NOP      = 2'd3;
  // Bound for the whole run; leave ample margin over the slowest legal run.
  localparam int         CYCLE_LIMIT = 1_500_000;
  // Longest command: seven serial divisions at playback start or a segment change.
  localparam int         DRAIN_WAIT  = 300;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  kpi_in_t     in_data;
  logic        out_valid;
  kpi_out_t    out_data;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int pending;
  int errors;
  int cycles = 0;
  int burst_left = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keyframe_pose_interpolator #(.MAX_KEYFRAMES(KEYFRAMES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  kpi_pose_checker #(.MAX_KEYFRAMES(KEYFRAMES), .STEPS_ADDR(REG_STEPS)) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_pready (cfg_pready),
    .pending    (pending),
    .errors     (errors)
  );

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mix extremes, small Q16.16 values (visible motion) and raw random words.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'($urandom_range(0, 32'h0010_0000));
      3:       return -32'($urandom_range(0, 32'h0010_0000));
      default: return 32'($urandom());
    endcase
  endfunction

  // Pose fields are random on every command, even where the block ignores them.
  function automatic kpi_in_t make_cmd(input logic [1:0] op);
    kpi_in_t cmd;
    int      c;
    for (c = 0; c < NUM_CH; c++) cmd[WORD_W*(NUM_CH-1-c) +: WORD_W] = pick_word();
    cmd.opcode = op;
    return cmd;
  endfunction

  function automatic kpi_in_t flat_pose(input logic [1:0] op, input logic [WORD_W-1:0] w);
    kpi_in_t cmd;
    int      c;
    for (c = 0; c < NUM_CH; c++) cmd[WORD_W*(NUM_CH-1-c) +: WORD_W] = w;
    cmd.opcode = op;
    return cmd;
  endfunction

  function automatic logic [1:0] noise_op();
    case ($urandom_range(0, 3))
      0:       return OP_TICK;
      1:       return OP_SAVE;
      2:       return OP_PLAY;
      default: return OP_NOP;
    endcase
  endfunction

  // Bursts of random length, random gaps between them; now and then a long
  // burst with no idle cycle at all.
  task automatic pace();
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
  endtask

  // Hold the command until the block takes it (start high, busy low at an edge).
  task automatic send(input kpi_in_t cmd);
    pace();
    start   <= 1'b1;
    in_data <= cmd;
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every outstanding result has been transferred.
  task automatic finish_pending();
    start      <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  // Two-phase register write: setup, then access with pready.
  task automatic write_steps(input logic [STEP_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= REG_STEPS;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // One register setting: mostly a play, then a random run of ticks that, for
  // step settings up to 4, can cross segment ends and finish playback, with
  // stray commands mixed in; the rest are short bursts of random commands.
  task automatic run_phase(input logic [STEP_W-1:0] steps, input int count);
    int sent;
    int span;
    int n_ticks;
    logic [1:0] op;
    write_steps(steps);
    sent = 0;
    span = (steps > 4) ? 40 : 16 * (int'(steps) + 1) + 4;
    while (sent < count) begin
      if ($urandom_range(0, 4) != 0) begin
        send(make_cmd(OP_PLAY));
        sent++;
        n_ticks = $urandom_range(1, span);
        repeat (n_ticks) begin
          op = ($urandom_range(0, 19) == 0) ? noise_op() : OP_TICK;
          send(make_cmd(op));
          if (op != OP_NOP) sent++;
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          op = noise_op();
          send(make_cmd(op));
          if (op != OP_NOP) sent++;
        end
      end
    end
    // Sender pauses here until the block has drained.
    finish_pending();
  endtask

  initial begin
    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_data     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // One-tick segments so a single tick must land exactly on the next frame.
    write_steps(16'd1);
    send(make_cmd(OP_TICK));                      // tick while stopped
    send(make_cmd(OP_NOP));                       // unused opcode
    send(make_cmd(OP_PLAY));                      // play with an empty store
    send(flat_pose(OP_SAVE, 32'h8000_0000));      // most negative pose
    send(make_cmd(OP_PLAY));                      // play with one frame
    send(flat_pose(OP_SAVE, 32'h7FFF_FFFF));      // most positive pose
    send(make_cmd(OP_PLAY));                      // start: full-width difference
    send(make_cmd(OP_TICK));                      // wraps the quotient, lands on frame 1
    send(make_cmd(OP_TICK));                      // last segment ends, playback stops
    send(make_cmd(OP_TICK));
    send(make_cmd(OP_PLAY));
    send(make_cmd(OP_PLAY));                      // play while playing stops
    send('{opcode: OP_SAVE, pos_x_in: 32'h7FFF_FFFF, pos_y_in: 32'h8000_0000,
           pos_z_in: 32'h0000_0000, body_rot_in: 32'hFFFF_FFFF,
           head_rot_in: 32'h0000_0001, right_arm_rot_in: 32'h0001_0000,
           left_arm_rot_in: 32'hFFFF_0000});
    send(make_cmd(OP_PLAY));
    send(make_cmd(OP_SAVE));                      // save during playback extends the run
    repeat (8) send(make_cmd(OP_TICK));           // walk through all three segments
    finish_pending();

    run_phase(16'd1, 100);
    run_phase(16'd0, 60);                         // every tick during playback ends a segment
    run_phase(16'd2, 110);
    run_phase(16'd3, 110);
    run_phase(16'hFFFF, 50);
    run_phase(STEPS_RESET, 60);
    run_phase(16'($urandom_range(4, 9)), 100);
    run_phase(16'd1, 100);
    run_phase(16'($urandom_range(1, 3)), 120);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
